FILE: rtl/core/bdq_pkg.sv
`default_nettype none
package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OP_W      = 3;
  localparam int DATA_W    = 8;
  localparam int OCC_W     = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
  } bdq_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/bdq_ctrl.sv
`default_nettype none
module bdq_ctrl import bdq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output bdq_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bdq_dp.sv
`default_nettype none
module bdq_dp import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bdq_cmd_t          cmd,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [DATA_W-1:0] data_in,
  output logic [DATA_W-1:0]      data_out,
  output logic                   status,
  output logic [OCC_W-1:0]       occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(2 * DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  logic [OP_W-1:0]   op_r;
  logic [DATA_W-1:0] din_r;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              fail_r, fail_nxt;
  logic              pop_r, pop_nxt;
  logic [DATA_W-1:0] dout_r;

  logic              full, empty;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [AW-1:0]     front_dec, front_inc, back_pos, last_pos;

  function automatic logic [AW-1:0] wrap(input logic [PW-1:0] v);
    logic [PW-1:0] w;
    w = (v >= PW'(DEPTH)) ? v - PW'(DEPTH) : v;
    return w[AW-1:0];
  endfunction

  always_comb begin
    full      = (count_r == CW'(DEPTH));
    empty     = (count_r == '0);
    front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
    front_inc = wrap(PW'(front_r) + PW'(1));
    back_pos  = wrap(PW'(front_r) + PW'(count_r));
    last_pos  = wrap(PW'(front_r) + PW'(count_r) - PW'(1));

    front_nxt = front_r;
    count_nxt = count_r;
    fail_nxt  = 1'b0;
    pop_nxt   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = back_pos;
    rd_addr   = front_r;

    unique case (op_r)
      OP_PUSH_FRONT: begin
        if (full) begin
          fail_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = front_dec;
          front_nxt = front_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          fail_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          fail_nxt = 1'b1;
        end else begin
          pop_nxt   = 1'b1;
          front_nxt = front_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          fail_nxt = 1'b1;
        end else begin
          pop_nxt   = 1'b1;
          rd_addr   = last_pos;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_CLEAR: begin
        front_nxt = '0;
        count_nxt = '0;
      end
      default: begin
        fail_nxt = 1'b1;
      end
    endcase
  end

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem_r[wr_addr] <= din_r;
    end
    rdata_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= operation;
      din_r <= data_in;
    end
    if (cmd.exec) begin
      fail_r <= fail_nxt;
      pop_r  <= pop_nxt;
    end
    if (cmd.capture) begin
      dout_r <= pop_r ? rdata_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  assign data_out  = dout_r;
  assign status    = fail_r;
  assign occupancy = OCC_W'(count_r);

endmodule
`default_nettype wire

FILE: rtl/core/byte_deque_top.sv
`default_nettype none
// bounded byte deque on a ring of DEPTH entries: in_tuser selects push front, push back,
// pop front, pop back or clear, and every request returns one result with the popped byte
// (zero unless a pop succeeded), a fail flag (pop when empty, push when full, unknown code)
// and the occupancy after the request, masked to 5 bits. one request is handled at a time:
// accept, ring update with the storage read issued, read data capture, then the result is
// held until taken, and a new request is accepted only once it has been taken; the
// capture step is there because the ring storage has a registered read port. stored bytes
// are not cleared by reset or by a clear request, only the pointers.
module byte_deque_top import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_in[7:0]
  input  wire logic [2:0]  in_tuser,   // operation[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // data_out[7:0], occupancy[12:8], zero pad
  output logic [0:0]       out_tuser   // status[0]
);

  bdq_cmd_t          cmd;
  logic [DATA_W-1:0] data_out;
  logic              status;
  logic [OCC_W-1:0]  occupancy;

  bdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bdq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .operation (in_tuser),
    .data_in   (in_tdata),
    .data_out  (data_out),
    .status    (status),
    .occupancy (occupancy)
  );

  assign out_tdata = {3'b000, occupancy, data_out};
  assign out_tuser = status;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request accepted while result pending");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result shown in the cycle after accept");

  a_fail_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[7:0] == 8'd0))
    else $error("failed request returned nonzero data");

endmodule
`default_nettype wire
